[rtl/hd_pkg.sv]
`timescale 1ns / 1ps
// shared constants and helper functions for the haversine distance block
// no dependencies
`default_nettype none

package hd_pkg;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int ROM_DEPTH = 41;
  localparam int ANG_W = 35;
  localparam int CW = 34;
  localparam int SQ_STEPS = 31;
  localparam int ADDR_W = 3;

  localparam logic [22:0] RADIUS_RESET = 23'd6378137;
  localparam logic [ADDR_W-1:0] ADDR_RADIUS = 3'd0;
  localparam logic [29:0] KD = 30'd599690565;
  localparam logic signed [ANG_W-1:0] PI_Q30 = 35'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [CW-1:0] GAIN_INV = 34'sd652032874;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [32:0] DIST_TOP = 33'd5242880000;

  // arctangent of 2^-i in q30
  localparam logic [31:0] ATAN_ROM [ROM_DEPTH] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536,
    32'd32768, 32'd16384, 32'd8192, 32'd4096, 32'd2048,
    32'd1024, 32'd512, 32'd256, 32'd128, 32'd64,
    32'd32, 32'd16, 32'd8, 32'd4, 32'd2,
    32'd1, 32'd1, 32'd0, 32'd0, 32'd0,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
    32'd0
  };

  // degrees * 2^23 to radians q30, halved when half is set
  function automatic logic signed [ANG_W-1:0] deg_to_angle(input logic signed [32:0] deg,
                                                           input logic half);
    logic [32:0] mag;
    logic [62:0] prod;
    logic [62:0] r;
    mag = deg[32] ? 33'(-deg) : 33'(deg);
    prod = 63'(mag) * 63'(KD);
    if (half) begin
      r = (prod + 63'(1 << 28)) >> 29;
    end else begin
      r = (prod + 63'(1 << 27)) >> 28;
    end
    return deg[32] ? -$signed(r[ANG_W-1:0]) : $signed(r[ANG_W-1:0]);
  endfunction

  // q30 product rounded toward the nearest, ties up
  function automatic logic signed [37:0] mul_q30(input logic signed [35:0] a,
                                                 input logic signed [35:0] b);
    logic signed [71:0] p;
    p = 72'(a) * 72'(b) + 72'sd536870912;
    return p[67:30];
  endfunction

endpackage

`default_nettype wire

[rtl/hd_if.sv]
`timescale 1ns / 1ps
// valid/ready channels for point pairs and distances
// no dependencies
`default_nettype none

interface hd_points_if;
  logic valid;
  logic ready;
  logic signed [30:0] first_latitude;
  logic signed [31:0] first_longitude;
  logic signed [30:0] second_latitude;
  logic signed [31:0] second_longitude;
  modport source (output valid, first_latitude, first_longitude, second_latitude,
                  second_longitude, input ready);
  modport sink (input valid, first_latitude, first_longitude, second_latitude,
                second_longitude, output ready);
endinterface

interface hd_dist_if;
  logic valid;
  logic ready;
  logic [32:0] distance;
  modport source (output valid, distance, input ready);
  modport sink (input valid, distance, output ready);
endinterface

`default_nettype wire

[rtl/haversine_distance.sv]
`timescale 1ns / 1ps
// Great-circle distance between two points by the haversine formula, fully pipelined.
// One point pair is taken every cycle while the output is not stalled; each pair passes through
// two CORDIC chains of CORDIC_STAGES stages and a 31-stage square root.
// A stall at the output holds the whole pipeline. Distances are in 1/256 metre.
// Uses hd_pkg and the interfaces in hd_if.sv.
`default_nettype none

module haversine_distance
  import hd_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  hd_points_if.sink              points,
  hd_dist_if.source              result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int S = CORDIC_STAGES;
  localparam int LAT = 2 * S + 39;

  logic [22:0] radius;
  logic adv;
  logic [LAT-1:0] vld;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_RADIUS) ? {9'd0, radius} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_RADIUS) begin
      radius <= pwdata[22:0];
    end
  end

  // global pipeline advance
  assign adv = !vld[LAT-1] || result.ready;
  assign points.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], points.valid};
    end
  end

  // input register
  logic signed [30:0] lat1, lat2;
  logic signed [31:0] lon1, lon2;

  always_ff @(posedge clk) begin
    if (adv) begin
      lat1 <= points.first_latitude;
      lon1 <= points.first_longitude;
      lat2 <= points.second_latitude;
      lon2 <= points.second_longitude;
    end
  end

  // degree to radian scaling, lanes: dlat/2, dlon/2, lat1, lat2
  logic signed [ANG_W-1:0] ang [4];
  logic signed [32:0] dlat, dlon;

  assign dlat = 33'(lat2) - 33'(lat1);
  assign dlon = 33'(lon2) - 33'(lon1);

  always_ff @(posedge clk) begin
    if (adv) begin
      ang[0] <= deg_to_angle(dlat, 1'b1);
      ang[1] <= deg_to_angle(dlon, 1'b1);
      ang[2] <= deg_to_angle(33'(lat1), 1'b0);
      ang[3] <= deg_to_angle(33'(lat2), 1'b0);
    end
  end

  // rotation cordic chain
  logic signed [CW-1:0]    cx [S+1][4];
  logic signed [CW-1:0]    cy [S+1][4];
  logic signed [ANG_W-1:0] cz [S+1][4];
  logic                    cneg [S+1][4];

  for (genvar k = 0; k < 4; k++) begin : g_reduce
    logic signed [ANG_W-1:0] w;
    always_comb begin
      w = ang[k];
      if (w > PI_Q30) begin
        w = w - (PI_Q30 <<< 1);
      end else if (w < -PI_Q30) begin
        w = w + (PI_Q30 <<< 1);
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        cx[0][k] <= GAIN_INV;
        cy[0][k] <= '0;
        if (w > HALF_PI_Q30) begin
          cz[0][k] <= PI_Q30 - w;
          cneg[0][k] <= 1'b1;
        end else if (w < -HALF_PI_Q30) begin
          cz[0][k] <= -PI_Q30 - w;
          cneg[0][k] <= 1'b1;
        end else begin
          cz[0][k] <= w;
          cneg[0][k] <= 1'b0;
        end
      end
    end
  end

  for (genvar i = 0; i < S; i++) begin : g_rot
    localparam logic signed [ANG_W-1:0] T = ANG_W'(ATAN_ROM[i]);
    for (genvar k = 0; k < 4; k++) begin : g_lane
      always_ff @(posedge clk) begin
        if (adv) begin
          cneg[i+1][k] <= cneg[i][k];
          if (!cz[i][k][ANG_W-1]) begin
            cx[i+1][k] <= cx[i][k] - (cy[i][k] >>> i);
            cy[i+1][k] <= cy[i][k] + (cx[i][k] >>> i);
            cz[i+1][k] <= cz[i][k] - T;
          end else begin
            cx[i+1][k] <= cx[i][k] + (cy[i][k] >>> i);
            cy[i+1][k] <= cy[i][k] - (cx[i][k] >>> i);
            cz[i+1][k] <= cz[i][k] + T;
          end
        end
      end
    end
  end

  // haversine term a
  logic signed [CW-1:0] c1, c2;
  logic signed [37:0] p1, p2, p3, p1d, p4;
  logic signed [38:0] asum;
  logic [30:0] aq;

  assign c1 = cneg[S][2] ? -cx[S][2] : cx[S][2];
  assign c2 = cneg[S][3] ? -cx[S][3] : cx[S][3];
  assign asum = 39'(p1d) + 39'(p4);

  always_ff @(posedge clk) begin
    if (adv) begin
      p1 <= mul_q30(36'(cy[S][0]), 36'(cy[S][0]));
      p2 <= mul_q30(36'(c1), 36'(c2));
      p3 <= mul_q30(36'(cy[S][1]), 36'(cy[S][1]));
      p1d <= p1;
      p4 <= mul_q30(p2[35:0], p3[35:0]);
      if (asum < 0) begin
        aq <= '0;
      end else if (asum > 39'(ONE_Q30)) begin
        aq <= ONE_Q30;
      end else begin
        aq <= asum[30:0];
      end
    end
  end

  // digit by digit square roots of a and 1-a in q60
  logic [63:0] srem [SQ_STEPS+1][2];
  logic [30:0] sroot [SQ_STEPS+1][2];

  assign srem[0][0] = {33'd0, aq} << 30;
  assign srem[0][1] = {33'd0, ONE_Q30 - aq} << 30;
  assign sroot[0][0] = '0;
  assign sroot[0][1] = '0;

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    localparam int B = SQ_STEPS - 1 - j;
    for (genvar k = 0; k < 2; k++) begin : g_lane
      logic [63:0] trial;
      assign trial = ({33'd0, sroot[j][k]} << (B + 1)) + (64'd1 << (2 * B));
      always_ff @(posedge clk) begin
        if (adv) begin
          if (srem[j][k] >= trial) begin
            srem[j+1][k] <= srem[j][k] - trial;
            sroot[j+1][k] <= sroot[j][k] | (31'd1 << B);
          end else begin
            srem[j+1][k] <= srem[j][k];
            sroot[j+1][k] <= sroot[j][k];
          end
        end
      end
    end
  end

  // vectoring cordic chain for atan2
  logic signed [CW-1:0]    vx [S+1];
  logic signed [CW-1:0]    vy [S+1];
  logic signed [ANG_W-1:0] vz [S+1];

  assign vy[0] = CW'(sroot[SQ_STEPS][0]);
  assign vx[0] = CW'(sroot[SQ_STEPS][1]);
  assign vz[0] = '0;

  for (genvar i = 0; i < S; i++) begin : g_vec
    localparam logic signed [ANG_W-1:0] T = ANG_W'(ATAN_ROM[i]);
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!vy[i][CW-1]) begin
          vx[i+1] <= vx[i] + (vy[i] >>> i);
          vy[i+1] <= vy[i] - (vx[i] >>> i);
          vz[i+1] <= vz[i] + T;
        end else begin
          vx[i+1] <= vx[i] - (vy[i] >>> i);
          vy[i+1] <= vy[i] + (vx[i] >>> i);
          vz[i+1] <= vz[i] - T;
        end
      end
    end
  end

  // scale by radius, round and saturate
  logic [31:0] cang;
  logic [54:0] dprod;
  logic [32:0] dshift;
  logic [32:0] dist_out;

  assign cang = vz[S][ANG_W-1] ? 32'd0 : 32'(vz[S] <<< 1);
  assign dshift = 33'((dprod + 55'(1 << 21)) >> 22);

  always_ff @(posedge clk) begin
    if (adv) begin
      dprod <= 55'(radius) * 55'(cang);
      dist_out <= (dshift > DIST_TOP) ? DIST_TOP : dshift;
    end
  end

  assign result.valid = vld[LAT-1];
  assign result.distance = dist_out;

`ifndef ASSERT_OFF
  a_enter: assert property (@(posedge clk) disable iff (rst)
    points.valid && points.ready |=> vld[0])
    else $error("accepted transaction not tracked");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld) && $stable(dist_out))
    else $error("pipeline moved during stall");
  a_top: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> dist_out <= DIST_TOP)
    else $error("distance above saturation value");
  a_rst: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("output valid after reset");
`endif

endmodule

`default_nettype wire

[tb/sv/tb_haversine_distance.sv]
`timescale 1ns / 1ps
// self-checking testbench for haversine_distance: directed table then random point pairs
// with random stalls on both channels, checked against a fixed-point predictor
// depends on hd_pkg, hd_if.sv and the haversine_distance rtl
`default_nettype none

module tb_haversine_distance;
  import hd_pkg::*;

  localparam logic [ADDR_W-1:0] ADDR_UNUSED = 3'd4;
  localparam int STAGES = CORDIC_STAGES_DEF;
  localparam int LATENCY = 2 * STAGES + 39;
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam longint LAT_MAX = 754974720;
  localparam longint LON_MAX = 1509949440;
  localparam int N_RANDOM = 430;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic signed [30:0] lat1;
    logic signed [31:0] lon1;
    logic signed [30:0] lat2;
    logic signed [31:0] lon2;
  } pair_t;

  typedef struct {
    pair_t       p;
    logic [22:0] radius;
    bit          has_exp;
    logic [32:0] exp_dist;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  hd_points_if points ();
  hd_dist_if result ();

  haversine_distance i_dut (
    .clk(clk), .rst(rst), .points(points.sink), .result(result.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic [22:0] radius_m;
  logic [32:0] dist_queue[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_saturated = 0;
  int max_gap = 15;
  int max_stall = 15;
  bit hold_req = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_haversine_distance failed");
    $finish;
  end

  // fixed-point predictor
  function automatic longint atan_entry(int i);
    longint sum;
    int k;
    int e;
    sum = 0;
    if (i == 0) return longint'((PI_Q60 + (64'd1 << 31)) >> 32);
    for (k = 0; i * (2 * k + 1) <= 62; k++) begin
      e = 62 - i * (2 * k + 1);
      if (k % 2 == 1) sum -= longint'((64'd1 << e) / (2 * k + 1));
      else sum += longint'((64'd1 << e) / (2 * k + 1));
    end
    return longint'((64'(sum) + (64'd1 << 31)) >> 32);
  endfunction

  function automatic longint to_radians(longint deg, int shift);
    logic [63:0] kd;
    logic [63:0] mag;
    logic [63:0] r;
    kd = (PI_Q60 / 180 + (64'd1 << 24)) >> 25;
    mag = (deg < 0) ? 64'(-deg) : 64'(deg);
    r = (mag * kd + (64'd1 << (shift - 1))) >> shift;
    return (deg < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint round_mul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic void rotate_sin_cos(longint ang, output longint s, output longint c);
    longint pi;
    longint half;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    bit neg;
    pi = longint'((PI_Q60 + (64'd1 << 29)) >> 30);
    half = longint'((PI_Q60 + (64'd1 << 30)) >> 31);
    x = 652032874;
    y = 0;
    neg = 1'b0;
    while (ang > pi) ang -= 2 * pi;
    while (ang < -pi) ang += 2 * pi;
    if (ang > half) begin
      ang = pi - ang;
      neg = 1'b1;
    end else if (ang < -half) begin
      ang = -pi - ang;
      neg = 1'b1;
    end
    z = ang;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_entry(i);
      end else begin
        x += dx; y -= dy; z += atan_entry(i);
      end
    end
    s = y;
    c = neg ? -x : x;
  endfunction

  function automatic longint vector_atan2(longint y, longint x);
    longint z;
    longint dx;
    longint dy;
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_entry(i);
      end else begin
        x -= dx; y += dy; z -= atan_entry(i);
      end
    end
    return z;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [32:0] great_circle_dist(pair_t p, logic [22:0] radius);
    longint la1, lo1, la2, lo2;
    longint sl, cl, so, co, s1, c1, s2, c2, a, c, d;
    la1 = p.lat1; lo1 = p.lon1; la2 = p.lat2; lo2 = p.lon2;
    rotate_sin_cos(to_radians(la2 - la1, 29), sl, cl);
    rotate_sin_cos(to_radians(lo2 - lo1, 29), so, co);
    rotate_sin_cos(to_radians(la1, 28), s1, c1);
    rotate_sin_cos(to_radians(la2, 28), s2, c2);
    a = round_mul(sl, sl) + round_mul(round_mul(c1, c2), round_mul(so, so));
    if (a < 0) a = 0;
    if (a > (64'sd1 <<< 30)) a = 64'sd1 <<< 30;
    c = 2 * vector_atan2(longint'(floor_sqrt(64'(a) << 30)),
                         longint'(floor_sqrt(64'((64'sd1 <<< 30) - a) << 30)));
    if (c < 0) c = 0;
    d = (longint'(radius) * c + (64'sd1 <<< 21)) >>> 22;
    if (d > longint'(DIST_TOP)) d = DIST_TOP;
    return d[32:0];
  endfunction

  task automatic report(string what, logic [32:0] got, logic [32:0] want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  // result monitor
  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      if (dist_queue.size() == 0) begin
        report("unexpected distance", result.distance, '0);
      end else begin
        if (result.distance !== dist_queue[0]) report("distance", result.distance, dist_queue[0]);
        if (dist_queue[0] == DIST_TOP) n_saturated++;
        void'(dist_queue.pop_front());
        n_checked++;
      end
    end
  end

  // result receiver with random stalls and one long hold-off
  initial begin
    int n;
    result.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      n = (max_stall == 0) ? 0 : $urandom_range(0, max_stall);
      if (hold_req) begin
        hold_req = 1'b0;
        n = HOLD_CYCLES;
      end
      if (n > 0) begin
        result.ready = 1'b0;
        repeat (n) @(negedge clk);
      end
      result.ready = 1'b1;
      do @(posedge clk); while (!result.valid);
      @(negedge clk);
    end
  end

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic drain();
    while (dist_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
  endtask

  task automatic set_radius(logic [22:0] r);
    drain();
    apb_write(ADDR_RADIUS, 32'(r));
    radius_m = r;
  endtask

  task automatic send_pair(pair_t p);
    int n;
    n = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
    if (n > 0) begin
      points.valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    points.valid = 1'b1;
    points.first_latitude = p.lat1;
    points.first_longitude = p.lon1;
    points.second_latitude = p.lat2;
    points.second_longitude = p.lon2;
    do @(posedge clk); while (!points.ready);
    dist_queue.insert(dist_queue.size(), great_circle_dist(p, radius_m));
    n_sent++;
    @(negedge clk);
    points.valid = 1'b0;
  endtask

  function automatic longint rand_in(longint lim);
    return longint'($urandom_range(0, 32'(2 * lim))) - lim;
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      p.lat1 = 31'(rand_in(LAT_MAX)); p.lon1 = 32'(rand_in(LON_MAX));
      p.lat2 = 31'(rand_in(LAT_MAX)); p.lon2 = 32'(rand_in(LON_MAX));
    end else if (kind < 8) begin
      p.lat1 = 31'(rand_in(LAT_MAX - 4096)); p.lon1 = 32'(rand_in(LON_MAX - 4096));
      p.lat2 = 31'(p.lat1 + rand_in($urandom_range(1, 4096)));
      p.lon2 = 32'(p.lon1 + rand_in($urandom_range(1, 4096)));
    end else begin
      p.lat1 = 31'($urandom); p.lon1 = $urandom; p.lat2 = 31'($urandom); p.lon2 = $urandom;
    end
    return p;
  endfunction

  row_t table_rows[$];

  function automatic void add_row(longint a1, longint o1, longint a2, longint o2,
                                  logic [22:0] r, int has_exp, longint e);
    row_t row;
    row.p.lat1 = 31'(a1); row.p.lon1 = 32'(o1); row.p.lat2 = 31'(a2); row.p.lon2 = 32'(o2);
    row.radius = r; row.has_exp = (has_exp != 0); row.exp_dist = 33'(e);
    table_rows.insert(table_rows.size(), row);
  endfunction

  initial begin
    pair_t p;
    logic [22:0] radii[5];
    logic [32:0] want;
    longint deg90;
    deg90 = 90 * (64'sd1 <<< 23);
    radii = '{23'd6000000, 23'd6500000, 23'h7FFFFF, 23'd6371000, 23'd0};
    points.valid = 1'b0;
    points.first_latitude = '0;
    points.first_longitude = '0;
    points.second_latitude = '0;
    points.second_longitude = '0;
    radius_m = RADIUS_RESET;

    add_row(0, 0, 0, 0, RADIUS_RESET, 0, 0);
    add_row(0, 0, 0, 2 * deg90, RADIUS_RESET, 0, 0);
    add_row(deg90, 0, -deg90, 0, RADIUS_RESET, 0, 0);
    add_row(LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX, RADIUS_RESET, 0, 0);
    add_row(12345678, -98765432, 12345679, -98765431, RADIUS_RESET, 0, 0);
    add_row(-deg90 / 2, deg90, deg90 / 3, -deg90 * 3 / 2, RADIUS_RESET, 0, 0);
    add_row(-(64'sd1 <<< 30), -(64'sd1 <<< 31), (64'sd1 <<< 30) - 1, (64'sd1 <<< 31) - 1,
            RADIUS_RESET, 0, 0);
    add_row((64'sd1 <<< 30) - 1, (64'sd1 <<< 31) - 1, -(64'sd1 <<< 30), -(64'sd1 <<< 31),
            RADIUS_RESET, 0, 0);
    add_row(0, 0, 0, 2 * deg90, 23'h7FFFFF, 1, DIST_TOP);
    add_row(deg90, 0, -deg90, 0, 23'h7FFFFF, 1, DIST_TOP);
    add_row(deg90 / 5, 7777, -deg90 / 7, 3 * deg90, 23'h7FFFFF, 0, 0);
    add_row(0, 0, 0, 2 * deg90, 23'd0, 1, 0);
    add_row(LAT_MAX, -LON_MAX, 0, LON_MAX, 23'd0, 1, 0);
    add_row(0, 0, deg90 / 2, deg90 / 2, 23'd6000000, 0, 0);
    add_row(0, 0, deg90 / 2, deg90 / 2, 23'd6500000, 0, 0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // the write to an unmapped address must leave the radius alone
    apb_write(ADDR_UNUSED, 32'd1234);
    foreach (table_rows[i]) begin
      if (table_rows[i].radius != radius_m) set_radius(table_rows[i].radius);
      if (table_rows[i].has_exp) begin
        want = great_circle_dist(table_rows[i].p, radius_m);
        if (want !== table_rows[i].exp_dist) report("table row", want, table_rows[i].exp_dist);
      end
      send_pair(table_rows[i].p);
    end

    for (int ph = 0; ph < 5; ph++) begin
      set_radius(radii[ph]);
      max_gap = (ph == 2) ? 0 : 15;
      max_stall = (ph == 3) ? 0 : 15;
      for (int k = 0; k < N_RANDOM / 5; k++) begin
        if (ph == 1 && k == 10) begin
          max_gap = 0;
          hold_req = 1'b1;
        end
        if (ph == 1 && k == 60) max_gap = 15;
        p = rand_pair();
        send_pair(p);
      end
    end

    drain();
    $display("sent %0d point pairs over six radius values, %0d distances checked",
             n_sent, n_checked);
    $display("saturated distances seen: %0d, mismatches: %0d", n_saturated, errors);
    if (errors == 0) begin
      $display("tb_haversine_distance passed");
    end else begin
      $display("tb_haversine_distance failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
